// ===== rtl/dec_pkg.sv =====
// Shared types, constants and saturation helpers for the disc collision pipeline.
// No dependencies; disc_elastic_collision.sv refers to it by scoped names.
package dec_pkg;

    localparam int POS_W  = 20;
    localparam int VEL_W  = 17;
    localparam int RAD_W  = 16;
    localparam int MASS_W = 16;

    localparam logic [POS_W-1:0] POS_MAX = 20'hFFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MAX = 17'sh0FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 17'sh10000;

    // Clock edges from input transaction to output register load
    localparam int LAT = 55;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_HIT  = 2'd1,
        ST_COIN = 2'd2
    } status_t;

    // Input item, first field of the transaction (pos_a_x) in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [MASS_W-1:0] mass_b;
        logic [RAD_W-1:0]  radius_b;
        logic [VEL_W-1:0]  vel_b_y;
        logic [VEL_W-1:0]  vel_b_x;
        logic [POS_W-1:0]  pos_b_y;
        logic [POS_W-1:0]  pos_b_x;
        logic [MASS_W-1:0] mass_a;
        logic [RAD_W-1:0]  radius_a;
        logic [VEL_W-1:0]  vel_a_y;
        logic [VEL_W-1:0]  vel_a_x;
        logic [POS_W-1:0]  pos_a_y;
        logic [POS_W-1:0]  pos_a_x;
    } in_item_t;

    // Positions and velocities of both discs, result order
    typedef struct packed {
        logic [VEL_W-1:0] vel_b_y;
        logic [VEL_W-1:0] vel_b_x;
        logic [POS_W-1:0] pos_b_y;
        logic [POS_W-1:0] pos_b_x;
        logic [VEL_W-1:0] vel_a_y;
        logic [VEL_W-1:0] vel_a_x;
        logic [POS_W-1:0] pos_a_y;
        logic [POS_W-1:0] pos_a_x;
    } kin_t;

    typedef struct packed {
        logic [3:0] pad;
        kin_t       kin;
    } out_item_t;

    // Per-item decision flags carried down the pipeline
    typedef struct packed {
        logic contact;
        logic coin;
        logic mzero;
    } flags_t;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic [POS_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({2'b00, POS_MAX}))
            r = POS_MAX;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VEL_W+3:0] v);
        logic [VEL_W-1:0] r;
        if (v < (VEL_W+4)'(VEL_MIN))
            r = VEL_MIN;
        else if (v > (VEL_W+4)'(VEL_MAX))
            r = VEL_MAX;
        else
            r = v[VEL_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/dec_delay.sv =====
// Enabled shift line that aligns side data with the arithmetic stages.
// No package dependency.
module dec_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    // Advance all taps together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== rtl/dec_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage (floor).
// No package dependency.
module dec_sqrt #(
    parameter int IN_W = 34
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);

    localparam int R_W  = IN_W / 2;
    localparam int RM_W = R_W + 3;

    logic [IN_W-1:0] v_reg    [R_W];
    logic [RM_W-1:0] rem_reg  [R_W];
    logic [R_W-1:0]  root_reg [R_W];

    for (genvar k = 0; k < R_W; k++)
    begin : g_step
        localparam int I = R_W - 1 - k;
        logic [IN_W-1:0] v_in;
        logic [RM_W-1:0] rem_in;
        logic [R_W-1:0]  root_in;
        logic [RM_W-1:0] rem_sh;
        logic [RM_W-1:0] trial;
        logic [RM_W-1:0] rem_next;
        logic [R_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down the next bit pair and try the next root bit
        always_comb
        begin
            rem_sh = {rem_in[RM_W-3:0], v_in[2*I+1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[R_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= v_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[R_W-1];

endmodule

// ===== rtl/dec_rdiv.sv =====
// Pipelined signed division rounded to nearest, halves away from zero.
// Restoring, one quotient bit per stage; inputs and result are registered. No package dependency.
module dec_rdiv #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 18,
    parameter int Q_W   = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic signed [Q_W:0]     quo
);

    localparam int CW = DEN_W + Q_W;

    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] biased;
    logic [CW-1:0]    m_reg;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;

    logic [CW-1:0]    rem_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [DEN_W-1:0] dp_reg  [Q_W];
    logic             np_reg  [Q_W];

    logic signed [Q_W:0] quo_reg;

    // Take the magnitude and add half the divisor for rounding
    always_comb
    begin
        mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        biased = mag + NUM_W'(den >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= CW'(biased);
            d_reg   <= den;
            neg_reg <= num[NUM_W-1];
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int I = Q_W - 1 - k;
        logic [CW-1:0]    rem_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W-1:0] d_in;
        logic             n_in;
        logic [CW-1:0]    dsh;
        logic [CW-1:0]    rem_next;
        logic [Q_W-1:0]   q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = m_reg;
            assign q_in   = '0;
            assign d_in   = d_reg;
            assign n_in   = neg_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = dp_reg[k-1];
            assign n_in   = np_reg[k-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb
        begin
            dsh = {{Q_W{1'b0}}, d_in} << I;
            if (rem_in >= dsh)
            begin
                rem_next = rem_in - dsh;
                q_next   = q_in | (Q_W'(1) << I);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                dp_reg[k]  <= d_in;
                np_reg[k]  <= n_in;
            end
        end
    end

    // Restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= np_reg[Q_W-1] ? -$signed({1'b0, q_reg[Q_W-1]})
                                     : $signed({1'b0, q_reg[Q_W-1]});
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/disc_elastic_collision.sv =====
// The result of an input transaction can be taken on m_axis once it has passed the pipeline,
// whose length is set by the longest path (impulse divide, mass divide).
// Throughput: one disc pair per cycle; the whole pipeline halts while a result
// waits on m_axis_tready.
// Reset (rst_n low, asynchronous) empties the pipeline; no results are pending.
// Uses dec_pkg, dec_delay, dec_sqrt, dec_rdiv.
module disc_elastic_collision (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a, mass_a,
    // pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b, mass_b, 4 zero bits
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y,
    // new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y, 4 zero bits
    output logic [151:0] m_axis_tdata,
    // contact_status
    output logic [1:0]   m_axis_tuser
);

    localparam int LAT = dec_pkg::LAT;

    dec_pkg::in_item_t it;
    dec_pkg::kin_t     raw_in;
    dec_pkg::kin_t     raw54;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;

    // Stage 1
    logic signed [20:0] dx1_reg, dy1_reg;
    logic signed [17:0] dvx1_reg, dvy1_reg;
    logic [16:0]        rs1_reg, msum1_reg;
    logic [15:0]        ma1_reg, mb1_reg;
    // Stage 2
    logic signed [41:0] sqx2_reg, sqy2_reg;
    logic signed [38:0] pdx2_reg, pdy2_reg;
    logic [33:0]        rsq2_reg;
    logic signed [17:0] dx2_reg, dy2_reg;
    logic [16:0]        rs2_reg, msum2_reg;
    logic [15:0]        ma2_reg, mb2_reg;
    // Stage 3
    logic [42:0]        d2_3_reg;
    logic signed [39:0] dot3_reg;
    dec_pkg::flags_t    fl3_reg;
    logic signed [17:0] dx3_reg, dy3_reg;
    logic [16:0]        rs3_reg, msum3_reg;
    logic [15:0]        ma3_reg, mb3_reg;
    // Stage 4
    logic signed [53:0] prx4_reg, pry4_reg;
    logic [33:0]        d2_4_reg;

    logic [16:0]        dist20;
    logic [16:0]        rs20;
    logic [35:0]        dxy21;
    logic [16:0]        ov21_reg;
    logic [17:0]        den21_reg;
    logic signed [35:0] cnx22_reg, cny22_reg;
    logic [17:0]        den22_reg;
    logic signed [16:0] cx40, cy40;
    logic [33:0]        cxy54;
    logic signed [26:0] qx32, qy32;
    logic [48:0]        m32;
    logic [15:0]        ma32, mb32;
    logic [16:0]        msum32;
    logic signed [44:0] vnax33_reg, vnay33_reg, vnbx33_reg, vnby33_reg;
    logic [24:0]        vden33_reg;
    logic signed [19:0] dvax54, dvay54, dvbx54, dvby54;
    dec_pkg::flags_t    fl54;

    dec_pkg::out_item_t out_next, out_reg;
    dec_pkg::status_t   status_next, status_reg;

    assign it = dec_pkg::in_item_t'(s_axis_tdata);

    // Advance the whole pipeline unless a result is held at the output
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign vld_next      = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Stage 1: center and velocity differences, radius and mass sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg   <= $signed({1'b0, it.pos_b_x}) - $signed({1'b0, it.pos_a_x});
            dy1_reg   <= $signed({1'b0, it.pos_b_y}) - $signed({1'b0, it.pos_a_y});
            dvx1_reg  <= $signed({it.vel_b_x[16], it.vel_b_x})
                       - $signed({it.vel_a_x[16], it.vel_a_x});
            dvy1_reg  <= $signed({it.vel_b_y[16], it.vel_b_y})
                       - $signed({it.vel_a_y[16], it.vel_a_y});
            rs1_reg   <= {1'b0, it.radius_a} + {1'b0, it.radius_b};
            msum1_reg <= {1'b0, it.mass_a} + {1'b0, it.mass_b};
            ma1_reg   <= it.mass_a;
            mb1_reg   <= it.mass_b;
        end
    end

    // Stage 2: squares and velocity projections
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx2_reg  <= dx1_reg * dx1_reg;
            sqy2_reg  <= dy1_reg * dy1_reg;
            rsq2_reg  <= rs1_reg * rs1_reg;
            pdx2_reg  <= dvx1_reg * dx1_reg;
            pdy2_reg  <= dvy1_reg * dy1_reg;
            dx2_reg   <= $signed(dx1_reg[17:0]);
            dy2_reg   <= $signed(dy1_reg[17:0]);
            rs2_reg   <= rs1_reg;
            msum2_reg <= msum1_reg;
            ma2_reg   <= ma1_reg;
            mb2_reg   <= mb1_reg;
        end
    end

    // Stage 3: squared distance, dot product, contact, coincidence and zero-mass flags
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_3_reg <= 43'($unsigned(sqx2_reg)) + 43'($unsigned(sqy2_reg));
            dot3_reg <= 40'(pdx2_reg) + 40'(pdy2_reg);
            fl3_reg.contact <= (43'($unsigned(sqx2_reg)) + 43'($unsigned(sqy2_reg)))
                             < 43'(rsq2_reg);
            fl3_reg.coin    <= (sqx2_reg == '0) && (sqy2_reg == '0);
            fl3_reg.mzero   <= (msum2_reg == '0);
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            rs3_reg   <= rs2_reg;
            msum3_reg <= msum2_reg;
            ma3_reg   <= ma2_reg;
            mb3_reg   <= mb2_reg;
        end
    end

    // Stage 4: dot times each center difference
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx4_reg <= $signed(dot3_reg[35:0]) * dx3_reg;
            pry4_reg <= $signed(dot3_reg[35:0]) * dy3_reg;
            d2_4_reg <= d2_3_reg[33:0];
        end
    end

    // Distance between centers
    dec_sqrt #(.IN_W(34)) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (d2_3_reg[33:0]),
        .root     (dist20)
    );

    dec_delay #(.W(17), .DEPTH(17)) u_dly_rs (
        .clk (clk), .en (en), .din (rs3_reg), .dout (rs20)
    );

    dec_delay #(.W(36), .DEPTH(18)) u_dly_dxy (
        .clk (clk), .en (en), .din ({dy3_reg, dx3_reg}), .dout (dxy21)
    );

    // Overlap and correction divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ov21_reg  <= rs20 - dist20;
            den21_reg <= {dist20, 1'b0};
        end
    end

    // Correction numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnx22_reg <= $signed(dxy21[17:0]) * $signed({1'b0, ov21_reg});
            cny22_reg <= $signed(dxy21[35:18]) * $signed({1'b0, ov21_reg});
            den22_reg <= den21_reg;
        end
    end

    dec_rdiv #(.NUM_W(36), .DEN_W(18), .Q_W(16)) u_div_cx (
        .clk (clk), .en (en), .num (cnx22_reg), .den (den22_reg), .quo (cx40)
    );

    dec_rdiv #(.NUM_W(36), .DEN_W(18), .Q_W(16)) u_div_cy (
        .clk (clk), .en (en), .num (cny22_reg), .den (den22_reg), .quo (cy40)
    );

    dec_delay #(.W(34), .DEPTH(14)) u_dly_cxy (
        .clk (clk), .en (en), .din ({cy40, cx40}), .dout (cxy54)
    );

    // Impulse along the center line, scaled by 256
    dec_rdiv #(.NUM_W(62), .DEN_W(34), .Q_W(26)) u_div_qx (
        .clk (clk), .en (en), .num ($signed({prx4_reg, 8'h00})), .den (d2_4_reg),
        .quo (qx32)
    );

    dec_rdiv #(.NUM_W(62), .DEN_W(34), .Q_W(26)) u_div_qy (
        .clk (clk), .en (en), .num ($signed({pry4_reg, 8'h00})), .den (d2_4_reg),
        .quo (qy32)
    );

    dec_delay #(.W(49), .DEPTH(29)) u_dly_m (
        .clk (clk), .en (en), .din ({msum3_reg, mb3_reg, ma3_reg}), .dout (m32)
    );

    assign ma32   = m32[15:0];
    assign mb32   = m32[31:16];
    assign msum32 = m32[48:32];

    // Mass-weighted impulse numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vnax33_reg <= qx32 * $signed({1'b0, mb32, 1'b0});
            vnay33_reg <= qy32 * $signed({1'b0, mb32, 1'b0});
            vnbx33_reg <= qx32 * $signed({1'b0, ma32, 1'b0});
            vnby33_reg <= qy32 * $signed({1'b0, ma32, 1'b0});
            vden33_reg <= {msum32, 8'h00};
        end
    end

    dec_rdiv #(.NUM_W(45), .DEN_W(25), .Q_W(19)) u_div_vax (
        .clk (clk), .en (en), .num (vnax33_reg), .den (vden33_reg), .quo (dvax54)
    );

    dec_rdiv #(.NUM_W(45), .DEN_W(25), .Q_W(19)) u_div_vay (
        .clk (clk), .en (en), .num (vnay33_reg), .den (vden33_reg), .quo (dvay54)
    );

    dec_rdiv #(.NUM_W(45), .DEN_W(25), .Q_W(19)) u_div_vbx (
        .clk (clk), .en (en), .num (vnbx33_reg), .den (vden33_reg), .quo (dvbx54)
    );

    dec_rdiv #(.NUM_W(45), .DEN_W(25), .Q_W(19)) u_div_vby (
        .clk (clk), .en (en), .num (vnby33_reg), .den (vden33_reg), .quo (dvby54)
    );

    dec_delay #(.W($bits(dec_pkg::flags_t)), .DEPTH(51)) u_dly_fl (
        .clk (clk), .en (en), .din (fl3_reg), .dout (fl54)
    );

    assign raw_in.pos_a_x = it.pos_a_x;
    assign raw_in.pos_a_y = it.pos_a_y;
    assign raw_in.vel_a_x = it.vel_a_x;
    assign raw_in.vel_a_y = it.vel_a_y;
    assign raw_in.pos_b_x = it.pos_b_x;
    assign raw_in.pos_b_y = it.pos_b_y;
    assign raw_in.vel_b_x = it.vel_b_x;
    assign raw_in.vel_b_y = it.vel_b_y;

    dec_delay #(.W($bits(dec_pkg::kin_t)), .DEPTH(54)) u_dly_raw (
        .clk (clk), .en (en), .din (raw_in), .dout (raw54)
    );

    // Apply corrections and impulses, saturate
    always_comb
    begin
        out_next     = '0;
        out_next.kin = raw54;
        status_next  = dec_pkg::ST_NONE;
        if (fl54.contact && fl54.coin)
        begin
            status_next = dec_pkg::ST_COIN;
        end
        else if (fl54.contact)
        begin
            status_next = dec_pkg::ST_HIT;
            out_next.kin.pos_a_x = dec_pkg::sat_pos($signed({2'b00, raw54.pos_a_x})
                                                    - 22'($signed(cxy54[16:0])));
            out_next.kin.pos_a_y = dec_pkg::sat_pos($signed({2'b00, raw54.pos_a_y})
                                                    - 22'($signed(cxy54[33:17])));
            out_next.kin.pos_b_x = dec_pkg::sat_pos($signed({2'b00, raw54.pos_b_x})
                                                    + 22'($signed(cxy54[16:0])));
            out_next.kin.pos_b_y = dec_pkg::sat_pos($signed({2'b00, raw54.pos_b_y})
                                                    + 22'($signed(cxy54[33:17])));
            if (!fl54.mzero)
            begin
                out_next.kin.vel_a_x = dec_pkg::sat_vel(21'($signed(raw54.vel_a_x))
                                                        + 21'(dvax54));
                out_next.kin.vel_a_y = dec_pkg::sat_vel(21'($signed(raw54.vel_a_y))
                                                        + 21'(dvay54));
                out_next.kin.vel_b_x = dec_pkg::sat_vel(21'($signed(raw54.vel_b_x))
                                                        - 21'(dvbx54));
                out_next.kin.vel_b_y = dec_pkg::sat_vel(21'($signed(raw54.vel_b_y))
                                                        - 21'(dvby54));
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg    <= out_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = status_reg;

    // A stalled pipeline keeps every valid bit in place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // Coincident centers in contact pass both discs through unchanged
    a_coin_pass: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-2] && fl54.contact && fl54.coin
        |=> status_reg == dec_pkg::ST_COIN && out_reg.kin == $past(raw54))
        else $error("coincident pair was modified");

    // Without contact vel_a_x and vel_b_y leave unchanged
    a_nohit_vel: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-2] && !fl54.contact
        |=> status_reg == dec_pkg::ST_NONE
            && out_reg.kin.vel_b_y == $past(raw54.vel_b_y)
            && out_reg.kin.vel_a_x == $past(raw54.vel_a_x))
        else $error("velocity changed without contact");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for disc_elastic_collision: drives disc pairs on s_axis,
// predicts each collision result in integer arithmetic and compares it on m_axis.
// Depends on dec_pkg and the RTL under rtl/.
module tb_top;

    typedef struct {
        logic [19:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;
        logic [16:0] vel_a_x, vel_a_y, vel_b_x, vel_b_y;
        logic [1:0]  status;
    } disc_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    disc_result_t expected_q[$];
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;
    bit           calm = 1'b0;
    int           idle_pct = 35;

    disc_elastic_collision u_top (.*);

    always #5 clk = ~clk;

    // Round num/den to nearest, halves away from zero; den > 0
    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v)
                r = r + (64'sd1 <<< b);
        return r;
    endfunction

    function automatic logic [19:0] clamp_pos(longint v);
        if (v < 0) return '0;
        if (v > 1048575) return 20'hFFFFF;
        return v[19:0];
    endfunction

    function automatic logic [16:0] clamp_vel(longint v);
        if (v < -65536) v = -65536;
        if (v > 65535) v = 65535;
        return v[16:0];
    endfunction

    function automatic disc_result_t resolve_collision(dec_pkg::in_item_t it);
        disc_result_t r;
        longint pax, pay, pbx, pby, vax, vay, vbx, vby, ra, rb, ma, mb;
        longint dx, dy, d2, rs, cdist, ov, msum, cx, cy, dot, qx, qy, den, nvax, nvay;
        pax = it.pos_a_x; pay = it.pos_a_y; pbx = it.pos_b_x; pby = it.pos_b_y;
        vax = $signed(it.vel_a_x); vay = $signed(it.vel_a_y);
        vbx = $signed(it.vel_b_x); vby = $signed(it.vel_b_y);
        ra = it.radius_a; rb = it.radius_b; ma = it.mass_a; mb = it.mass_b;
        dx = pbx - pax; dy = pby - pay;
        d2 = dx * dx + dy * dy;
        rs = ra + rb;
        r.status = dec_pkg::ST_NONE;
        if (d2 < rs * rs)
        begin
            if (d2 == 0)
            begin
                r.status = dec_pkg::ST_COIN;
            end
            else
            begin
                cdist = int_sqrt(d2);
                ov = rs - cdist;
                msum = ma + mb;
                cx = round_div(dx * ov, 2 * cdist);
                cy = round_div(dy * ov, 2 * cdist);
                r.status = dec_pkg::ST_HIT;
                if (msum != 0)
                begin
                    dot = (vbx - vax) * dx + (vby - vay) * dy;
                    qx = round_div(dot * dx * 256, d2);
                    qy = round_div(dot * dy * 256, d2);
                    den = msum * 256;
                    nvax = vax + round_div(qx * 2 * mb, den);
                    nvay = vay + round_div(qy * 2 * mb, den);
                    vbx = vbx - round_div(qx * 2 * ma, den);
                    vby = vby - round_div(qy * 2 * ma, den);
                    vax = nvax;
                    vay = nvay;
                end
                pax -= cx; pay -= cy; pbx += cx; pby += cy;
            end
        end
        r.pos_a_x = clamp_pos(pax); r.pos_a_y = clamp_pos(pay);
        r.pos_b_x = clamp_pos(pbx); r.pos_b_y = clamp_pos(pby);
        r.vel_a_x = clamp_vel(vax); r.vel_a_y = clamp_vel(vay);
        r.vel_b_x = clamp_vel(vbx); r.vel_b_y = clamp_vel(vby);
        return r;
    endfunction

    // Send one disc pair, with random idle cycles before it
    task automatic send_pair(dec_pkg::in_item_t it);
        it.pad = '0;
        while (!calm && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_q = {expected_q, resolve_collision(it)};
        @(negedge clk);
    endtask

    function automatic dec_pkg::in_item_t rand_pair();
        dec_pkg::in_item_t it;
        it = 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.mass_a = 16'($urandom_range(65535, 1));
        it.mass_b = 16'($urandom_range(65535, 1));
        return it;
    endfunction

    // Pair placed near contact: B offset from A by a small random vector
    function automatic dec_pkg::in_item_t near_pair();
        dec_pkg::in_item_t it;
        int span;
        it = rand_pair();
        span = 1 << $urandom_range(16, 4);
        it.pos_b_x = it.pos_a_x + 20'($urandom_range(2 * span) - span);
        it.pos_b_y = it.pos_a_y + 20'($urandom_range(2 * span) - span);
        if ($urandom_range(3) == 0) it.mass_a = 16'($urandom_range(3, 1));
        if ($urandom_range(3) == 0) it.radius_a = 16'($urandom_range(65535, 60000));
        return it;
    endfunction

    // Receive side: random stall, check each result transaction
    always @(negedge clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        disc_result_t       e;
        dec_pkg::out_item_t o;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            o = m_axis_tdata;
            if (expected_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                e = expected_q.pop_front();
                if (o.kin.pos_a_x !== e.pos_a_x || o.kin.pos_a_y !== e.pos_a_y ||
                    o.kin.vel_a_x !== e.vel_a_x || o.kin.vel_a_y !== e.vel_a_y ||
                    o.kin.pos_b_x !== e.pos_b_x || o.kin.pos_b_y !== e.pos_b_y ||
                    o.kin.vel_b_x !== e.vel_b_x || o.kin.vel_b_y !== e.vel_b_y ||
                    m_axis_tuser !== e.status || o.pad !== 4'd0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp A(%h %h %h %h) B(%h %h %h %h) st %0d",
                            e.pos_a_x, e.pos_a_y, e.vel_a_x, e.vel_a_y, e.pos_b_x,
                            e.pos_b_y, e.vel_b_x, e.vel_b_y, e.status,
                            "\n          got A(%h %h %h %h) B(%h %h %h %h) st %0d",
                            o.kin.pos_a_x, o.kin.pos_a_y, o.kin.vel_a_x, o.kin.vel_a_y,
                            o.kin.pos_b_x, o.kin.pos_b_y, o.kin.vel_b_x, o.kin.vel_b_y,
                            m_axis_tuser);
                end
            end
        end
        if (cycle_cnt > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        dec_pkg::in_item_t it;
        // Extremes, no contact
        it = '1; it.pos_a_x = '0; it.pos_a_y = '0; it.radius_a = '0; it.radius_b = '0;
        send_pair(it);
        it = '0; it.mass_a = 16'd1; it.mass_b = 16'd1;
        send_pair(it);                                   // zero radii at one point
        it.radius_a = 16'hFFFF; it.radius_b = 16'hFFFF;
        it.vel_a_x = 17'h10000; it.vel_b_y = 17'h0FFFF;
        send_pair(it);                                   // coincident centres
        // Head-on hit, approaching and separating
        it = '0; it.mass_a = 16'd1; it.mass_b = 16'd1;
        it.pos_a_x = 20'd1000; it.pos_a_y = 20'd5000; it.pos_b_x = 20'd1400;
        it.pos_b_y = 20'd5000; it.radius_a = 16'd256; it.radius_b = 16'd256;
        it.vel_a_x = 17'd512; it.vel_b_x = -17'sd512;
        send_pair(it);
        it.vel_a_x = -17'sd512; it.vel_b_x = 17'd512;
        send_pair(it);
        // Pushback saturates at both position ends
        it.pos_a_x = 20'd0; it.pos_b_x = 20'd10; it.radius_a = 16'hFFFF;
        send_pair(it);
        it.pos_a_x = 20'hFFFF0; it.pos_b_x = 20'hFFFFF;
        send_pair(it);
        // Velocity saturation, very unequal masses
        it.vel_a_x = 17'h10000; it.vel_b_x = 17'h0FFFF;
        it.mass_a = 16'hFFFF; it.mass_b = 16'd1;
        send_pair(it);
        it.mass_a = 16'd1; it.mass_b = 16'hFFFF;
        send_pair(it);
        // Touching without contact, then just outside contact, on a diagonal
        it = '0; it.mass_a = 16'd7; it.mass_b = 16'd9; it.pos_a_x = 20'd3000;
        it.pos_a_y = 20'd3000; it.pos_b_x = 20'd3300; it.pos_b_y = 20'd3400;
        it.radius_a = 16'd250; it.radius_b = 16'd250; it.vel_a_y = 17'd300;
        send_pair(it);
        it.radius_b = 16'd249;
        send_pair(it);
        for (int i = 0; i < 10; i++) send_pair(near_pair());
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_pair(($urandom_range(9) < 7) ? near_pair() : rand_pair());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(600);
        calm = 1'b1;                      // long stretch at full rate
        test_random(300);
        calm = 1'b0;
        test_random(630);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (2 * dec_pkg::LAT) @(posedge clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
